@@ src/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// DCT package
// Shared constants, types and the cosine coefficient table of the 8x8 DCT.
// ----------------------------------------------------------------------------
package dct_pkg;

   localparam int SAMPLE_WIDTH  = 12;
   localparam int FRACTION_BITS = 16;
   localparam int CONST_BITS    = 24;
   localparam int COEF_WIDTH    = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_STORE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_product;
      logic accumulate;
      logic first_term;
   } mac_ctrl_type;

   // Cosine constants scaled by 2^24: c1, c2, c3, c4, c6, s1, s3.
   function automatic int cos_q24(input logic [2:0] id);
      int value;
      begin
         unique case (id)
            3'd0:    value = 16454846;
            3'd1:    value = 15500126;
            3'd2:    value = 13949745;
            3'd3:    value = 11863283;
            3'd4:    value = 6420363;
            3'd5:    value = 3273072;
            3'd6:    value = 9320922;
            default: value = 0;
         endcase
         return value;
      end
   endfunction

   // Entry (k, j) of the 8-point DCT matrix as the butterflies of the fast
   // factorization expand it, reduced to frac fraction bits. Even rows are
   // symmetric about the middle of the row, odd rows antisymmetric.
   function automatic int dct_coef(input logic [2:0] k, input logic [2:0] j,
                                   input int frac);
      logic [2:0] id;
      logic       neg;
      logic [1:0] jj;
      logic       upper;
      int         mag;
      begin
         upper = j[2];
         jj    = upper ? ~j[1:0] : j[1:0];
         id    = 3'd3;
         neg   = 1'b0;
         unique case (k)
            3'd0: begin
               id = 3'd3;
            end
            3'd4: begin
               id  = 3'd3;
               neg = (jj == 2'd1) || (jj == 2'd2);
            end
            3'd2: begin
               id  = (jj == 2'd0 || jj == 2'd3) ? 3'd1 : 3'd4;
               neg = jj[1];
            end
            3'd6: begin
               id  = (jj == 2'd0 || jj == 2'd3) ? 3'd4 : 3'd1;
               neg = jj[0];
            end
            3'd1: begin
               unique case (jj)
                  2'd0: id = 3'd0;
                  2'd1: id = 3'd2;
                  2'd2: id = 3'd6;
                  default: id = 3'd5;
               endcase
               neg = upper;
            end
            3'd3: begin
               unique case (jj)
                  2'd0: id = 3'd2;
                  2'd1: id = 3'd5;
                  2'd2: id = 3'd0;
                  default: id = 3'd6;
               endcase
               neg = (jj != 2'd0) ^ upper;
            end
            3'd5: begin
               unique case (jj)
                  2'd0: id = 3'd6;
                  2'd1: id = 3'd0;
                  2'd2: id = 3'd5;
                  default: id = 3'd2;
               endcase
               neg = (jj == 2'd1) ^ upper;
            end
            default: begin
               unique case (jj)
                  2'd0: id = 3'd5;
                  2'd1: id = 3'd6;
                  2'd2: id = 3'd2;
                  default: id = 3'd0;
               endcase
               neg = (jj == 2'd1 || jj == 2'd3) ^ upper;
            end
         endcase
         mag = (cos_q24(id) + (1 <<< (CONST_BITS - 1 - frac))) >>> (CONST_BITS - frac);
         return neg ? -mag : mag;
      end
   endfunction

endpackage

@@ src/dct_2d_8x8_chen.sv @@
// ----------------------------------------------------------------------------
// 8x8 two-dimensional DCT
// Orthonormal 8x8 DCT over one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Contents
//  --------+-----------+---------------------------------------------------
//  req_    | in        | one sample per item, row-major within the block
//  rsp_    | out       | one coefficient per item, row by row, tlast on 64th
//
// Loading takes one sample per cycle while samples are offered. After the
// 64th sample the block works through the row pass and then the column
// pass, which also waits on the handshake of each coefficient. Each term
// goes through the single multiplier in order as a memory read, a multiply
// and an accumulate. Reset is synchronous and returns the sequencer to
// loading an empty block. The block takes no sample while it computes or
// emits; a stalled result holds the sequencer until it is taken.
//
// Every coefficient is formed directly as the matrix product of the fast
// factorization; since the butterflies are exact integer sums, the result is
// bit for bit that of the butterfly form.
module dct_2d_8x8_chen #(
   parameter int SAMPLE_WIDTH  = dct_pkg::SAMPLE_WIDTH,
   parameter int FRACTION_BITS = dct_pkg::FRACTION_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // bits up: sample
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // bits up: coefficient, vertical_frequency, horizontal_frequency
   output logic [39:0]                               rsp_tdata,
   output logic                                      rsp_tlast
);

   localparam int CW         = FRACTION_BITS + 2;
   localparam int ACC_W      = 32 + CW + 3;
   localparam int ROW_SHIFT  = 1;
   localparam int COL_SHIFT  = (FRACTION_BITS > 16) ? (2 * FRACTION_BITS - 15)
                                                     : (FRACTION_BITS + 1);
   localparam int COL_LSHIFT = (FRACTION_BITS < 16) ? (16 - FRACTION_BITS) : 0;

   localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] MIN32 = -ACC_W'(64'sh80000000);

   dct_pkg::state_type    state_ff, state_in;
   logic [5:0]            count_ff, count_in;
   logic [5:0]            idx_ff, idx_in;
   logic [2:0]            term_ff, term_in;
   logic                  pass_ff, pass_in;
   logic [31:0]           coef_ff, coef_in;

   dct_pkg::mac_ctrl_type mac_ctrl;
   logic signed [ACC_W-1:0] acc;
   logic signed [31:0]    operand_a;
   logic signed [CW-1:0]  operand_b;
   logic [2:0]            k_sel;

   logic                  sample_we;
   logic [5:0]            sample_addr;
   logic [SAMPLE_WIDTH-1:0] sample_rd;
   logic                  row_we;
   logic [5:0]            row_addr;
   logic [31:0]           row_rd;
   logic [31:0]           row_wr;

   logic signed [ACC_W-1:0] row_shift;
   logic signed [ACC_W-1:0] col_shift;
   logic signed [ACC_W-1:0] col_scaled;

   // Row pass: output {r, k} reads samples {r, j}. Column pass: output
   // {u, v} reads row results {j, v} with k = u.
   assign k_sel       = pass_ff ? idx_ff[5:3] : idx_ff[2:0];
   assign sample_addr = (state_ff == dct_pkg::ST_LOAD) ? count_ff : {idx_ff[5:3], term_ff};
   assign row_addr    = (state_ff == dct_pkg::ST_STORE) ? idx_ff : {term_ff, idx_ff[2:0]};
   assign sample_we   = (state_ff == dct_pkg::ST_LOAD) && req_tvalid;
   assign row_we      = (state_ff == dct_pkg::ST_STORE) && !pass_ff;

   assign operand_a = pass_ff ? $signed(row_rd)
                              : 32'($signed(sample_rd));
   assign operand_b = CW'(dct_pkg::dct_coef(k_sel, term_ff, FRACTION_BITS));

   // Shift with truncation toward zero, then saturation to 32 bits.
   assign row_shift  = (acc + (acc[ACC_W-1] ? ACC_W'((1 << ROW_SHIFT) - 1)
                                            : ACC_W'(0))) >>> ROW_SHIFT;
   assign col_shift  = (acc + (acc[ACC_W-1] ? ACC_W'((1 << COL_SHIFT) - 1)
                                            : ACC_W'(0))) >>> COL_SHIFT;
   assign col_scaled = col_shift <<< COL_LSHIFT;

   assign row_wr = (row_shift > MAX32) ? 32'h7FFFFFFF :
                   (row_shift < MIN32) ? 32'h80000000 : row_shift[31:0];

   dct_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(64)) u_sample_ram (
      .clock        (clock),
      .write_enable (sample_we),
      .address      (sample_addr),
      .write_data   (req_tdata[SAMPLE_WIDTH-1:0]),
      .read_data    (sample_rd)
   );

   dct_ram #(.WIDTH(32), .DEPTH(64)) u_row_ram (
      .clock        (clock),
      .write_enable (row_we),
      .address      (row_addr),
      .write_data   (row_wr),
      .read_data    (row_rd)
   );

   dct_mac #(.B_WIDTH(CW), .ACC_WIDTH(ACC_W)) u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .operand_a (operand_a),
      .operand_b (operand_b),
      .acc       (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dct_pkg::ST_LOAD;
         count_ff <= '0;
         idx_ff   <= '0;
         term_ff  <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         term_ff  <= term_in;
         pass_ff  <= pass_in;
      end
      coef_ff <= coef_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      term_in   = term_ff;
      pass_in   = pass_ff;
      coef_in   = coef_ff;
      mac_ctrl  = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         dct_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               count_in = count_ff + 6'd1;
               if (count_ff == 6'd63) begin
                  state_in = dct_pkg::ST_READ;
                  idx_in   = '0;
                  term_in  = '0;
                  pass_in  = 1'b0;
               end
            end
         end
         dct_pkg::ST_READ: begin
            state_in = dct_pkg::ST_MUL;
         end
         dct_pkg::ST_MUL: begin
            mac_ctrl.load_product = 1'b1;
            state_in = dct_pkg::ST_ACC;
         end
         dct_pkg::ST_ACC: begin
            mac_ctrl.accumulate = 1'b1;
            mac_ctrl.first_term = (term_ff == 3'd0);
            term_in = term_ff + 3'd1;
            state_in = (term_ff == 3'd7) ? dct_pkg::ST_STORE : dct_pkg::ST_READ;
         end
         dct_pkg::ST_STORE: begin
            if (pass_ff) begin
               coef_in = (col_scaled > MAX32) ? 32'h7FFFFFFF :
                         (col_scaled < MIN32) ? 32'h80000000 : col_scaled[31:0];
               state_in = dct_pkg::ST_EMIT;
            end else begin
               idx_in   = idx_ff + 6'd1;
               state_in = dct_pkg::ST_READ;
               if (idx_ff == 6'd63) begin
                  pass_in = 1'b1;
               end
            end
         end
         dct_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in   = idx_ff + 6'd1;
               state_in = (idx_ff == 6'd63) ? dct_pkg::ST_LOAD : dct_pkg::ST_READ;
            end
         end
         default: begin
            state_in = dct_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_tdata = {2'b00, idx_ff[2:0], idx_ff[5:3], coef_ff};
   assign rsp_tlast = rsp_tvalid && (idx_ff == 6'd63);

   // A result is never offered while samples are being taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result offered while loading samples");

   // The column pass, and only it, delivers results.
   a_emit_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pass_ff)
      else $error("result offered during row pass");

   // The block leaves loading only on the 64th sample.
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dct_pkg::ST_LOAD && state_in != dct_pkg::ST_LOAD) |->
         (count_ff == 6'd63))
      else $error("computation started on a partial block");

endmodule

@@ src/dct_ram.sv @@
// ----------------------------------------------------------------------------
// DCT generic RAM
// Single-port memory with one write or read per cycle and registered read.
// ----------------------------------------------------------------------------
module dct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

@@ src/dct_mac.sv @@
// ----------------------------------------------------------------------------
// DCT multiply-accumulate unit
// Registered signed product followed by a registered accumulator.
// ----------------------------------------------------------------------------
module dct_mac #(
   parameter int B_WIDTH   = 18,
   parameter int ACC_WIDTH = 53
) (
   input  logic                        clock,
   input  dct_pkg::mac_ctrl_type       ctrl,
   input  logic signed [31:0]          operand_a,
   input  logic signed [B_WIDTH-1:0]   operand_b,
   output logic signed [ACC_WIDTH-1:0] acc
);

   logic signed [31+B_WIDTH:0]   product_ff;
   logic signed [31+B_WIDTH:0]   product_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic signed [ACC_WIDTH-1:0]  product_ext;

   assign product_in  = operand_a * operand_b;
   assign product_ext = ACC_WIDTH'(product_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.accumulate) begin
         acc_in = ctrl.first_term ? product_ext : acc_ff + product_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_product) begin
         product_ff <= product_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ verif/dct_2d_8x8_chen_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 8x8 DCT testbench
// Streams whole 8x8 blocks into the transform and checks every coefficient
// against a typed-in value or a butterfly-form predictor of the fixed-point
// DCT, with random idling on both channels and one long output back-pressure.
// ----------------------------------------------------------------------------
module dct_2d_8x8_chen_tb;

   localparam int  CYCLE_LIMIT  = 600000;
   localparam int  DRAIN_CYCLES = 3500;  // extra wait after the last coefficient
   localparam int  LONG_HOLD    = 2500;

   typedef longint vec8_type [8];

   // Block shapes used by the stimulus table and the random part.
   typedef enum int {
      PAT_CONST,
      PAT_CHECKER,
      PAT_RANDOM,
      PAT_SMALL,
      PAT_RAMP
   } pattern_type;

   typedef struct {
      pattern_type pattern;
      int          level;
      bit          known;       // coefficient typed in below, not predicted
      int          known_coef;
   } block_row_type;

   typedef struct {
      logic [31:0] coef;
      logic [2:0]  vfreq;
      logic [2:0]  hfreq;
      logic        last;
   } coef_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // bits up: sample, zero fill
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // bits up: coefficient, vertical_frequency, horizontal_frequency, zero fill
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   dct_2d_8x8_chen uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the block being gathered and the coefficients still owed.
   longint        block_samples [64];
   int            gathered = 0;
   coef_item_type coef_queue [$];
   bit            known_queue [$];   // one flag per block, in sending order
   int            known_value_queue [$];
   int            errors = 0;
   int            coefs_seen = 0;
   int            samples_taken = 0;
   int            blocks_done = 0;
   longint        cycles = 0;

   // Seven cosines at 16 fraction bits, rounded from their 2^24 scaling.
   function automatic longint cos_q16(input int id);
      longint k24 [7] = '{16454846, 15500126, 13949745, 11863283,
                          6420363, 3273072, 9320922};
      return (k24[id] + (64'sd1 <<< (dct_pkg::CONST_BITS - dct_pkg::FRACTION_BITS - 1)))
             >>> (dct_pkg::CONST_BITS - dct_pkg::FRACTION_BITS);
   endfunction

   function automatic longint trunc_shift(input longint v, input int s);
      return (v < 0) ? -((-v) >>> s) : (v >>> s);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // One 8-point Chen pass: exact butterflies, then products scaled down by s.
   function automatic vec8_type chen_pass(input vec8_type a, input int s);
      longint c1, c2, c3, c4, c6, s1, s3;
      longint d0, d1, d2, d3, p0, p1, p2, p3, e0, e1, e2, e3;
      vec8_type y;
      c1 = cos_q16(0); c2 = cos_q16(1); c3 = cos_q16(2); c4 = cos_q16(3);
      c6 = cos_q16(4); s1 = cos_q16(5); s3 = cos_q16(6);
      p0 = a[0] + a[7]; d0 = a[0] - a[7];
      p1 = a[1] + a[6]; d1 = a[1] - a[6];
      p2 = a[2] + a[5]; d2 = a[2] - a[5];
      p3 = a[3] + a[4]; d3 = a[3] - a[4];
      e0 = p0 + p3; e1 = p1 + p2; e2 = p0 - p3; e3 = p1 - p2;
      y[0] = trunc_shift((e0 + e1) * c4, s);
      y[4] = trunc_shift((e0 - e1) * c4, s);
      y[2] = trunc_shift(c2 * e2 + c6 * e3, s);
      y[6] = trunc_shift(c6 * e2 - c2 * e3, s);
      y[1] = trunc_shift(c1 * d0 + c3 * d1 + s3 * d2 + s1 * d3, s);
      y[3] = trunc_shift(c3 * d0 - s1 * d1 - c1 * d2 - s3 * d3, s);
      y[5] = trunc_shift(s3 * d0 - c1 * d1 + s1 * d2 + c3 * d3, s);
      y[7] = trunc_shift(s1 * d0 - s3 * d1 + c3 * d2 - c1 * d3, s);
      return y;
   endfunction

   // Full 2-D transform of the gathered block; pushes its 64 coefficients.
   task automatic predict_block();
      longint        row_results [64];
      vec8_type      line, out;
      coef_item_type item;
      bit            known;
      int            known_coef;
      known      = known_queue.pop_front();
      known_coef = known_value_queue.pop_front();
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) line[c] = block_samples[r * 8 + c];
         out = chen_pass(line, 1);
         for (int c = 0; c < 8; c++) row_results[r * 8 + c] = clamp32(out[c]);
      end
      for (int c = 0; c < 8; c++) begin
         for (int r = 0; r < 8; r++) line[r] = row_results[r * 8 + c];
         out = chen_pass(line, dct_pkg::FRACTION_BITS + 1);
         // Column results land back in row-major order below.
         for (int r = 0; r < 8; r++) row_results[r * 8 + c] = clamp32(out[r]);
      end
      for (int i = 0; i < 64; i++) begin
         item.coef  = known ? known_coef : row_results[i][31:0];
         item.vfreq = i[5:3];
         item.hfreq = i[2:0];
         item.last  = (i == 63);
         coef_queue.push_back(item);
      end
   endtask

   // Sample side: every accepted item goes into the block being gathered.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         block_samples[gathered] = $signed(req_tdata[dct_pkg::SAMPLE_WIDTH-1:0]);
         samples_taken++;
         if (gathered == 63) begin
            gathered = 0;
            predict_block();
         end else begin
            gathered++;
         end
      end
   end

   // Coefficient side: compare each accepted item with the oldest prediction.
   always @(posedge clock) begin
      coef_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         coefs_seen++;
         if (coef_queue.size() == 0) begin
            $display("%0t: unexpected coefficient, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = coef_queue.pop_front();
            if (want.last) blocks_done++;
            if (rsp_tdata[31:0] !== want.coef) begin
               $display("%0t: coefficient expected %0d actual %0d", $time,
                        $signed(want.coef), $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[34:32] !== want.vfreq) begin
               $display("%0t: vertical frequency expected %0d actual %0d", $time,
                        want.vfreq, rsp_tdata[34:32]);
               errors++;
            end
            if (rsp_tdata[37:35] !== want.hfreq) begin
               $display("%0t: horizontal frequency expected %0d actual %0d", $time,
                        want.hfreq, rsp_tdata[37:35]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last flag expected %0b actual %0b", $time,
                        want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stalls per item, some stretches without any, and one
   // long hold-off in the second block so the sender backs up against the
   // block while it is still emitting.
   initial begin
      int stall;
      bit busy_stretch;
      int taken;
      taken = 0;
      @(negedge reset);
      forever begin
         if (taken % 48 == 0) busy_stretch = ($urandom_range(0, 2) != 0);
         stall = busy_stretch ? $urandom_range(0, 19) : 0;
         if (taken == 70) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Directed blocks: silence, both rails and the harshest alternation. Only
   // the all-zero block has coefficients that can be typed in (all zero).
   block_row_type block_table [4] = '{
      '{PAT_CONST,   0,     1'b1, 0},
      '{PAT_CONST,   2047,  1'b0, 0},
      '{PAT_CONST,   -2048, 1'b0, 0},
      '{PAT_CHECKER, 2047,  1'b0, 0}
   };

   function automatic logic [15:0] block_sample(input pattern_type pattern,
                                                input int level, input int i);
      int v;
      case (pattern)
         PAT_CONST:   v = level;
         PAT_CHECKER: v = ((i[3] ^ i[0]) != 0) ? -2048 : level;
         PAT_SMALL:   v = $urandom_range(0, 31) - 16;
         PAT_RAMP:    v = (i * 64) - 2048;
         default:     v = $urandom_range(0, 4095) - 2048;
      endcase
      return {4'b0, v[11:0]};
   endfunction

   // Sends one block of 64 items with random per-item gaps, or none at all.
   task automatic send_block(input pattern_type pattern, input int level,
                             input bit known, input int known_coef);
      int gap;
      bit gappy;
      gappy = ($urandom_range(0, 3) != 0);
      known_queue.push_back(known);
      known_value_queue.push_back(known_coef);
      for (int i = 0; i < 64; i++) begin
         gap = gappy ? $urandom_range(0, 19) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= block_sample(pattern, level, i);
         do @(posedge clock); while (!req_tready);
      end
   endtask

   initial begin
      pattern_type rand_pattern;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (block_table[n])
         send_block(block_table[n].pattern, block_table[n].level,
                    block_table[n].known, block_table[n].known_coef);

      // Random blocks: mostly full-range noise, with small-signal and ramp
      // blocks mixed in.
      for (int b = 0; b < 2; b++) begin
         case ($urandom_range(0, 5))
            0:       rand_pattern = PAT_SMALL;
            1:       rand_pattern = PAT_RAMP;
            default: rand_pattern = PAT_RANDOM;
         endcase
         send_block(rand_pattern, 0, 1'b0, 0);
      end
      req_tvalid <= 1'b0;

      // Let the last block compute and emit, then allow a little extra.
      while (coef_queue.size() != 0 || known_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples in %0d blocks, %0d coefficients checked,",
               samples_taken, blocks_done, coefs_seen);
      $display("including constant rails, a checkerboard and random content.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
